FILE: rtl/gjpc_pkg.sv
// Shared types and constants for the grid jump path counter.
package gjpc_pkg;

	// Fixed field widths.
	localparam int COORD_W = 4;
	localparam int COUNT_W = 64;

	// Default largest grid side.
	localparam int MAX_DIM_DEF = 16;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_ADD_CR,
		ST_ADD_DG,
		ST_WR_COL,
		ST_ADD_ROW,
		ST_WR_DG,
		ST_DONE
	} gjpc_state_t;

endpackage

FILE: rtl/gjpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gjpc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/gjpc_sat_add.sv
// Saturating 64-bit adder shared by every step of the cell update.
module gjpc_sat_add
	import gjpc_pkg::*;
(
	input  logic [COUNT_W-1:0] a,
	input  logic [COUNT_W-1:0] b,
	output logic [COUNT_W-1:0] sum,
	output logic               ovf
);

	logic [COUNT_W:0] raw;

	// A carry out means the true sum does not fit, so clamp to all ones.
	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		ovf = raw[COUNT_W];
		sum = raw[COUNT_W] ? {COUNT_W{1'b1}} : raw[COUNT_W-1:0];
	end

endmodule

FILE: rtl/grid_jump_path_counter_core.sv
// Grid jump path counter: fills cell counts backward with one shared saturating adder.
// An item fills N = (er-sr+1)*(ec-sc+1) cells, so at most 256 for a 16 by 16 rectangle;
// a rejected request goes from the clear state straight to done.
// Each cell takes one RAM read and five passes through the single adder.
// One item at a time: in_ready is high only while idle, after the result is taken.
// Reset clears the sequencer, valid bits and flags; sums are cleared per item by valid bits.
module grid_jump_path_counter_core
	import gjpc_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] start_row,
	input  logic [COORD_W-1:0] start_col,
	input  logic [COORD_W-1:0] end_row,
	input  logic [COORD_W-1:0] end_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] path_count,
	output logic               saturated,
	output logic               bad_request
);

	localparam int DIAG_DEPTH = 2 * MAX_DIM - 1;
	localparam int CW         = $clog2(MAX_DIM);
	localparam int DW         = $clog2(DIAG_DEPTH);

	gjpc_state_t state_q, state_d;

	logic [COORD_W-1:0] sr_q, sc_q, er_q, ec_q;
	logic [CW-1:0]      dr_q, dc_q, r_q, c_q;
	logic [DW-1:0]      d_idx;
	logic               req_bad;
	logic               first_cell, last_cell;

	logic [COUNT_W-1:0] t_q, v_q, row_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q, sat_q, bad_q;

	logic [MAX_DIM-1:0]    col_vld_q;
	logic [DIAG_DEPTH-1:0] diag_vld_q;

	logic [COUNT_W-1:0] col_rdata, diag_rdata, col_eff, diag_eff;
	logic [COUNT_W-1:0] add_a, add_b, add_sum;
	logic               add_ovf;
	logic               col_we, diag_we, add_en;

	// Diagonal index of the current cell, offset so it never goes negative.
	assign d_idx = DW'(r_q) + DW'(MAX_DIM - 1) - DW'(c_q);

	assign first_cell = (r_q == dr_q) && (c_q == dc_q);
	assign last_cell  = (r_q == '0) && (c_q == '0);

	// Start must not lie past the end, and the end must sit inside the grid.
	assign req_bad = (sr_q > er_q) || (sc_q > ec_q) ||
		(int'(er_q) >= MAX_DIM) || (int'(ec_q) >= MAX_DIM);

	// Entries not yet written for this item read as zero.
	assign col_eff  = col_vld_q[c_q]    ? col_rdata  : '0;
	assign diag_eff = diag_vld_q[d_idx] ? diag_rdata : '0;

	gjpc_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(MAX_DIM)
	) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (c_q),
		.wdata (add_sum),
		.raddr (c_q),
		.rdata (col_rdata)
	);

	gjpc_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DIAG_DEPTH)
	) u_diag_ram (
		.clk   (clk),
		.we    (diag_we),
		.waddr (d_idx),
		.wdata (add_sum),
		.raddr (d_idx),
		.rdata (diag_rdata)
	);

	gjpc_sat_add u_add (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum),
		.ovf (add_ovf)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_CLEAR;
			ST_CLEAR:   state_d = req_bad ? ST_DONE : ST_READ;
			ST_READ:    state_d = ST_ADD_CR;
			ST_ADD_CR:  state_d = ST_ADD_DG;
			ST_ADD_DG:  state_d = ST_WR_COL;
			ST_WR_COL:  state_d = ST_ADD_ROW;
			ST_ADD_ROW: state_d = ST_WR_DG;
			ST_WR_DG:   state_d = last_cell ? ST_DONE : ST_READ;
			ST_DONE:    if (out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Adder operand selection and write strobes.
	always_comb begin
		add_a   = col_eff;
		add_b   = row_q;
		add_en  = 1'b0;
		col_we  = 1'b0;
		diag_we = 1'b0;
		unique case (state_q)
			ST_ADD_CR: begin
				add_a  = col_eff;
				add_b  = row_q;
				add_en = 1'b1;
			end
			ST_ADD_DG: begin
				add_a  = t_q;
				add_b  = diag_eff;
				add_en = 1'b1;
			end
			ST_WR_COL: begin
				add_a  = col_eff;
				add_b  = v_q;
				add_en = 1'b1;
				col_we = 1'b1;
			end
			ST_ADD_ROW: begin
				add_a  = row_q;
				add_b  = v_q;
				add_en = 1'b1;
			end
			ST_WR_DG: begin
				add_a   = diag_eff;
				add_b   = v_q;
				add_en  = 1'b1;
				diag_we = 1'b1;
			end
			default: begin
				add_a = col_eff;
				add_b = row_q;
			end
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_DONE);
	assign path_count  = count_q;
	assign saturated   = sat_q;
	assign bad_request = bad_q;

	// Sequencer, valid bits and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_vld_q  <= '0;
			diag_vld_q <= '0;
			ovf_q      <= 1'b0;
			sat_q      <= 1'b0;
			bad_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				col_vld_q  <= '0;
				diag_vld_q <= '0;
				ovf_q      <= 1'b0;
				if (req_bad) begin
					sat_q <= 1'b0;
					bad_q <= 1'b1;
				end
			end
			if (add_en && add_ovf) begin
				ovf_q <= 1'b1;
			end
			if (col_we) begin
				col_vld_q[c_q] <= 1'b1;
			end
			if (diag_we) begin
				diag_vld_q[d_idx] <= 1'b1;
			end
			// The flag takes every earlier clamp plus any from the last cell's diagonal write,
			// even though that write does not feed the result.
			if (state_q == ST_WR_DG && last_cell) begin
				sat_q <= ovf_q || add_ovf;
				bad_q <= 1'b0;
			end
		end
	end

	// Datapath registers: coordinates, counters and running sums.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			sr_q <= start_row;
			sc_q <= start_col;
			er_q <= end_row;
			ec_q <= end_col;
		end
		if (state_q == ST_CLEAR) begin
			dr_q    <= CW'(int'(er_q) - int'(sr_q));
			dc_q    <= CW'(int'(ec_q) - int'(sc_q));
			r_q     <= CW'(int'(er_q) - int'(sr_q));
			c_q     <= CW'(int'(ec_q) - int'(sc_q));
			row_q   <= '0;
			count_q <= '0;
		end
		if (state_q == ST_ADD_CR) begin
			t_q <= add_sum;
		end
		// The end cell seeds the fill with a single empty path.
		if (state_q == ST_ADD_DG) begin
			v_q <= first_cell ? COUNT_W'(1) : add_sum;
		end
		if (state_q == ST_ADD_ROW) begin
			row_q <= add_sum;
		end
		// Step right to left, then move up a row with a fresh row sum.
		if (state_q == ST_WR_DG) begin
			if (last_cell) begin
				count_q <= v_q;
			end else if (c_q == '0) begin
				r_q   <= r_q - CW'(1);
				c_q   <= dc_q;
				row_q <= '0;
			end else begin
				c_q <= c_q - CW'(1);
			end
		end
	end

	// A new item is never taken while a result is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// A rejected request always reports a zero count with no clamp.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_request) |-> (path_count == '0 && !saturated))
		else $error("rejected request with nonzero count or clamp flag");

	// Once an item is taken the block stays busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !out_valid))
		else $error("block not busy after taking an item");

	// The fill starts at the end cell of the rectangle.
	a_fill_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && !req_bad) |=> (state_q == ST_READ && first_cell))
		else $error("fill did not start at the end cell");

endmodule
